// ===== sv/srtnq_pkg.sv =====
package srtnq_pkg;

  localparam int MAX_PROCS = 16;
  localparam int TIME_BITS = 32;
  localparam int PID_W = 5;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);

  typedef enum logic [1:0] {
    FUNC_ADD_READY   = 2'd0,
    FUNC_ADD_BLOCKED = 2'd1,
    FUNC_POP_READY   = 2'd2,
    FUNC_RELEASE     = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    Q_HOLD,
    Q_INSERT,
    Q_POP
  } q_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REPORT
  } state_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] key;
    logic [PID_W-1:0]     pid;
    logic [TIME_BITS-1:0] rem;
  } entry_t;

  typedef struct packed {
    q_op_t  op;
    entry_t entry;
  } q_ctl_t;

  typedef struct packed {
    entry_t head;
    logic   empty;
    logic   full;
  } q_status_t;

  typedef struct packed {
    func_t                func;
    logic [PID_W-1:0]     pid;
    logic [TIME_BITS-1:0] remaining_time;
    logic [TIME_BITS-1:0] block_duration;
    logic [TIME_BITS-1:0] current_time;
  } in_item_t;

  typedef struct packed {
    logic                 ok;
    logic [PID_W-1:0]     moved_pid;
    logic                 head_valid;
    logic [PID_W-1:0]     head_pid;
    logic [TIME_BITS-1:0] head_remaining;
    logic                 blocked_empty;
  } out_item_t;

endpackage

// ===== sv/srtnq_in_if.sv =====
interface srtnq_in_if;
  logic                valid;
  logic                ready;
  srtnq_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/srtnq_out_if.sv =====
interface srtnq_out_if;
  logic                 valid;
  logic                 ready;
  srtnq_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/srtn_ready_and_blocked_queues.sv =====
// Scheduler queue engine with a ready queue sorted by remaining time and a
// blocked queue sorted by release time, each a row of MAX_PROCS shift cells
// that insert in order (equal keys behind) or shift toward the head. An item
// passes through two states: EXEC, in which both cell rows carry out the
// operation, and REPORT, in which the new heads are captured into the output
// register; the next item is taken in REPORT once the output side is free,
// so a new item is never taken while one is executing. A release check moves
// at most one due blocked entry into the ready queue.
module srtn_ready_and_blocked_queues (
  input  logic        clk,
  input  logic        rst,
  srtnq_in_if.sink    req,
  srtnq_out_if.source rsp
);

  srtnq_pkg::state_t state;
  srtnq_pkg::state_t state_next;

  srtnq_pkg::func_t                       item_func;
  logic [srtnq_pkg::PID_W-1:0]            item_pid;
  logic [srtnq_pkg::TIME_BITS-1:0]        item_key;
  logic [srtnq_pkg::TIME_BITS-1:0]        item_rem;
  logic                                   res_ok;
  logic [srtnq_pkg::PID_W-1:0]            res_moved;
  logic                                   out_valid;
  srtnq_pkg::out_item_t                   out_data;

  logic                                   accept;
  logic                                   out_free;
  logic [srtnq_pkg::TIME_BITS:0]          rel_sum;
  logic [srtnq_pkg::TIME_BITS-1:0]        rel;
  logic [srtnq_pkg::TIME_BITS-1:0]        key_in;
  logic                                   exec_ok;
  logic [srtnq_pkg::PID_W-1:0]            exec_moved;
  srtnq_pkg::q_ctl_t                      ready_ctl;
  srtnq_pkg::q_ctl_t                      blocked_ctl;
  srtnq_pkg::q_status_t                   ready_st;
  srtnq_pkg::q_status_t                   blocked_st;

  srtnq_queue u_ready (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ready_ctl),
    .status (ready_st)
  );

  srtnq_queue u_blocked (
    .clk    (clk),
    .rst    (rst),
    .ctl    (blocked_ctl),
    .status (blocked_st)
  );

  assign out_free = !out_valid || rsp.ready;
  assign accept   = req.valid && req.ready;

  assign rel_sum = {1'b0, req.data.current_time} + {1'b0, req.data.block_duration};
  assign rel     = rel_sum[srtnq_pkg::TIME_BITS] ? '1 : rel_sum[srtnq_pkg::TIME_BITS-1:0];

  always_comb begin
    case (req.data.func)
      srtnq_pkg::FUNC_ADD_BLOCKED: key_in = rel;
      srtnq_pkg::FUNC_RELEASE:     key_in = req.data.current_time;
      default:                     key_in = req.data.remaining_time;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      srtnq_pkg::S_IDLE: begin
        if (accept) begin
          state_next = srtnq_pkg::S_EXEC;
        end
      end
      srtnq_pkg::S_EXEC: begin
        state_next = srtnq_pkg::S_REPORT;
      end
      srtnq_pkg::S_REPORT: begin
        if (out_free) begin
          state_next = accept ? srtnq_pkg::S_EXEC : srtnq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = srtnq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    req.ready         = 1'b0;
    ready_ctl.op      = srtnq_pkg::Q_HOLD;
    ready_ctl.entry   = '{key: item_key, pid: item_pid, rem: item_rem};
    blocked_ctl.op    = srtnq_pkg::Q_HOLD;
    blocked_ctl.entry = '{key: item_key, pid: item_pid, rem: item_rem};
    exec_ok           = 1'b0;
    exec_moved        = '0;
    case (state)
      srtnq_pkg::S_IDLE: begin
        req.ready = 1'b1;
      end
      srtnq_pkg::S_EXEC: begin
        case (item_func)
          srtnq_pkg::FUNC_ADD_READY: begin
            if (!ready_st.full) begin
              ready_ctl.op = srtnq_pkg::Q_INSERT;
              exec_ok      = 1'b1;
            end
          end
          srtnq_pkg::FUNC_ADD_BLOCKED: begin
            if (!blocked_st.full) begin
              blocked_ctl.op = srtnq_pkg::Q_INSERT;
              exec_ok        = 1'b1;
            end
          end
          srtnq_pkg::FUNC_POP_READY: begin
            if (!ready_st.empty) begin
              ready_ctl.op = srtnq_pkg::Q_POP;
              exec_ok      = 1'b1;
              exec_moved   = ready_st.head.pid;
            end
          end
          default: begin
            if (!blocked_st.empty && (blocked_st.head.key <= item_key) &&
                !ready_st.full) begin
              ready_ctl.op    = srtnq_pkg::Q_INSERT;
              ready_ctl.entry = '{key: blocked_st.head.rem, pid: blocked_st.head.pid,
                                  rem: blocked_st.head.rem};
              blocked_ctl.op  = srtnq_pkg::Q_POP;
              exec_ok         = 1'b1;
              exec_moved      = blocked_st.head.pid;
            end
          end
        endcase
      end
      srtnq_pkg::S_REPORT: begin
        req.ready = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= srtnq_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == srtnq_pkg::S_REPORT && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_func <= req.data.func;
      item_pid  <= req.data.pid;
      item_key  <= key_in;
      item_rem  <= req.data.remaining_time;
    end
    if (state == srtnq_pkg::S_EXEC) begin
      res_ok    <= exec_ok;
      res_moved <= exec_moved;
    end
    if (state == srtnq_pkg::S_REPORT && out_free) begin
      out_data.ok             <= res_ok;
      out_data.moved_pid      <= res_moved;
      out_data.head_valid     <= !ready_st.empty;
      out_data.head_pid       <= ready_st.empty ? '0 : ready_st.head.pid;
      out_data.head_remaining <= ready_st.empty ? '0 : ready_st.head.key;
      out_data.blocked_empty  <= blocked_st.empty;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

endmodule

// ===== sv/srtnq_cell.sv =====
module srtnq_cell (
  input  logic              clk,
  input  srtnq_pkg::q_ctl_t ctl,
  input  logic              occ,
  input  logic              left_le,
  input  srtnq_pkg::entry_t left_entry,
  input  srtnq_pkg::entry_t right_entry,
  output srtnq_pkg::entry_t entry,
  output logic              le
);

  // An occupied cell whose key is not above the new key stays ahead of it.
  assign le = occ && (entry.key <= ctl.entry.key);

  always_ff @(posedge clk) begin
    case (ctl.op)
      srtnq_pkg::Q_INSERT: begin
        if (!le) begin
          entry <= left_le ? ctl.entry : left_entry;
        end
      end
      srtnq_pkg::Q_POP: begin
        entry <= right_entry;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/srtnq_queue.sv =====
module srtnq_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  srtnq_pkg::q_ctl_t    ctl,
  output srtnq_pkg::q_status_t status
);

  logic [srtnq_pkg::CNT_W-1:0] count;
  srtnq_pkg::entry_t           entries [srtnq_pkg::MAX_PROCS];
  logic                        le      [srtnq_pkg::MAX_PROCS];

  for (genvar i = 0; i < srtnq_pkg::MAX_PROCS; i++) begin : g_cell
    srtnq_pkg::entry_t left_entry;
    srtnq_pkg::entry_t right_entry;
    logic              left_le;

    if (i == 0) begin : g_first
      assign left_entry = ctl.entry;
      assign left_le    = 1'b1;
    end else begin : g_mid
      assign left_entry = entries[i-1];
      assign left_le    = le[i-1];
    end

    if (i == srtnq_pkg::MAX_PROCS - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    srtnq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occ         (srtnq_pkg::CNT_W'(i) < count),
      .left_le     (left_le),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entries[i]),
      .le          (le[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (ctl.op)
        srtnq_pkg::Q_INSERT: count <= count + srtnq_pkg::CNT_W'(1);
        srtnq_pkg::Q_POP:    count <= count - srtnq_pkg::CNT_W'(1);
        default: begin
        end
      endcase
    end
  end

  assign status.head  = entries[0];
  assign status.empty = (count == '0);
  assign status.full  = (count == srtnq_pkg::CNT_W'(srtnq_pkg::MAX_PROCS));

endmodule

// ===== sv/srtnq_checker.sv =====
module srtnq_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  req_valid,
  input logic                                  req_ready,
  input logic                                  rsp_valid,
  input logic                                  rsp_ready,
  input logic                                  rsp_ok,
  input logic [srtnq_pkg::PID_W-1:0]           rsp_moved_pid,
  input logic                                  rsp_head_valid,
  input logic [srtnq_pkg::PID_W-1:0]           rsp_head_pid,
  input logic [srtnq_pkg::TIME_BITS-1:0]       rsp_head_remaining
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("Result item dropped while stalled.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("Result item shown right after reset.");

  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !(req_valid && req_ready))
    else $error("Input item taken while the previous one is still executing.");

  a_empty_head_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_head_valid |-> rsp_head_pid == '0 && rsp_head_remaining == '0)
    else $error("Empty ready queue reports a nonzero head.");

  a_moved_needs_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_moved_pid != '0 |-> rsp_ok)
    else $error("Moved pid reported on a failed operation.");

endmodule

bind srtn_ready_and_blocked_queues srtnq_checker u_srtnq_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_ok             (rsp.data.ok),
  .rsp_moved_pid      (rsp.data.moved_pid),
  .rsp_head_valid     (rsp.data.head_valid),
  .rsp_head_pid       (rsp.data.head_pid),
  .rsp_head_remaining (rsp.data.head_remaining)
);
